>>> rtl/cpsf_pkg.sv
// shared types and constants for the corridor point section filter
package cpsf_pkg;

  // field widths that do not vary
  localparam int TAG_BITS     = 32;
  localparam int CFG_IDX_BITS = 3;
  localparam int WIDTH_RESET  = 1024;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_END_X   = 3'd2,
    REG_END_Y   = 3'd3,
    REG_WIDTH   = 3'd4,
    REG_ACTIVE  = 3'd5
  } cpsf_reg_e;

  // item opcodes
  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } cpsf_op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN_MUL,
    ST_LEN_SQRT,
    ST_PT_MUL,
    ST_PT_ABS,
    ST_PT_DIV,
    ST_FINISH
  } cpsf_state_e;

  // control of one bit-serial multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic step;
    logic msb;
    logic sub1;
  } cpsf_mac_ctl_t;

  // control of the serial divider
  typedef struct packed {
    logic load;
    logic step;
  } cpsf_div_ctl_t;

endpackage

>>> rtl/cpsf_if.sv
// handshake channels of the corridor point section filter

// point item channel
interface cpsf_pt_if import cpsf_pkg::*; #(
  parameter int COORD_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic [0:0]                   opcode;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic [TAG_BITS-1:0]          node_tag;

  modport source (output valid, opcode, point_x, point_y, point_z, node_tag, input ready);
  modport sink (input valid, opcode, point_x, point_y, point_z, node_tag, output ready);
endinterface

// result item channel
interface cpsf_res_if import cpsf_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int COUNT_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic signed [COORD_BITS+1:0] station;
  logic signed [COORD_BITS-1:0] elevation;
  logic [TAG_BITS-1:0]          tag_out;
  logic [COUNT_BITS-1:0]        kept_count;
  logic signed [COORD_BITS+1:0] station_low;
  logic signed [COORD_BITS+1:0] station_high;
  logic signed [COORD_BITS-1:0] elevation_low;
  logic signed [COORD_BITS-1:0] elevation_high;
  logic [COORD_BITS:0]          line_length;

  modport source (output valid, accepted, station, elevation, tag_out, kept_count,
                  station_low, station_high, elevation_low, elevation_high,
                  line_length, input ready);
  modport sink (input valid, accepted, station, elevation, tag_out, kept_count,
                station_low, station_high, elevation_low, elevation_high,
                line_length, output ready);
endinterface

// configuration write channel
interface cpsf_cfg_if import cpsf_pkg::*; #(
  parameter int COORD_BITS = 24
) ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COORD_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/cpsf_smac.sv
// bit-serial two-term signed multiply-accumulate, one multiplier bit per cycle while step is set
module cpsf_smac import cpsf_pkg::*; #(
  parameter int AW    = 25,
  parameter int NSTEP = 25
) (
  input  logic                     clk_i,
  input  cpsf_mac_ctl_t            ctl_i,
  input  logic signed [AW-1:0]     a0_i,
  input  logic signed [AW-1:0]     a1_i,
  input  logic                     b0_i,
  input  logic                     b1_i,
  output logic signed [AW+1+NSTEP:0] prod_o
);

  localparam int HW = AW + 2;

  logic signed [HW-1:0]    hi_q, hi_d;
  logic [NSTEP-1:0]        lo_q, lo_d;
  logic signed [HW-1:0]    t0_w, t1_w, pp_w, ppn_w, sum_w;

  // partial product of this bit, negated on the sign bit of the multiplier
  always_comb begin
    t0_w  = b0_i ? HW'(a0_i) : '0;
    t1_w  = b1_i ? HW'(a1_i) : '0;
    pp_w  = ctl_i.sub1 ? (t0_w - t1_w) : (t0_w + t1_w);
    ppn_w = ctl_i.msb ? -pp_w : pp_w;
    sum_w = hi_q + ppn_w;
    hi_d  = sum_w >>> 1;
    lo_d  = {sum_w[0], lo_q[NSTEP-1:1]};
  end

  // accumulator: high part shifts right, finished low bits drop into lo_q
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (ctl_i.step) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod_o = {hi_q, lo_q};

endmodule

>>> rtl/cpsf_div.sv
// radix-2 restoring divider, one quotient bit per cycle while step is set, with overflow flag
module cpsf_div import cpsf_pkg::*; #(
  parameter int NW = 50,
  parameter int DW = 25,
  parameter int QW = 26
) (
  input  logic          clk_i,
  input  cpsf_div_ctl_t ctl_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [QW-1:0] quot_o,
  output logic          ovf_o
);

  localparam int CW = DW + 1;

  logic [DW-1:0] rem_q;
  logic [QW-1:0] nlo_q;
  logic [QW-1:0] quot_q;
  logic          ovf_q;
  logic [CW-1:0] trial_w, diff_w;
  logic          ge_w;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial_w = {rem_q, nlo_q[QW-1]};
    ge_w    = trial_w >= {1'b0, divisor_i};
    diff_w  = trial_w - {1'b0, divisor_i};
  end

  // quotient too wide when the dividend bits above it already reach the divisor
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rem_q <= DW'(dividend_i[NW-1:QW]);
      nlo_q <= dividend_i[QW-1:0];
      ovf_q <= CW'(dividend_i[NW-1:QW]) >= CW'(divisor_i);
    end else if (ctl_i.step) begin
      rem_q  <= ge_w ? diff_w[DW-1:0] : trial_w[DW-1:0];
      nlo_q  <= {nlo_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], ge_w};
    end
  end

  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

endmodule

>>> rtl/corridor_point_section_filter.sv
// corridor point section filter: keeps points near a plan line, gives station and statistics
//
// Channels: pt_i takes point items (add point or clear statistics), res_o gives
// one result item per point item, cfg_i writes the six line and corridor
// registers. All use valid/ready; an item moves when both are high.
// After reset, and after any configuration write, the block derives the line
// length with a bit-serial square and a digit-by-digit square root, with
// pt_i.ready low meanwhile; pt_i.ready is also low in any cycle in which a
// configuration write is offered.
// A point item then runs the bit-serial cross and dot products, a magnitude
// step and the radix-2 station divider, then a finish step that writes the
// result before the block returns to idle; pt_i.ready stays low until the
// block is back in idle, so one point item is worked on at a time.
// A clear item, or a point while the section is inactive or degenerate, goes
// straight to the finish step. The result waits in an output register; a
// stalled receiver does not stop the next item from being accepted and worked
// on, only its final step holds until the output register is free.
// Reset clears the statistics, the output valid and the configuration, but sets the corridor width to WIDTH_RESET.
module corridor_point_section_filter import cpsf_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpsf_pt_if.sink   pt_i,
  cpsf_res_if.source res_o,
  cpsf_cfg_if.sink  cfg_i
);

  localparam int C     = COORD_BITS;
  localparam int D     = COORD_BITS + 1;
  localparam int SB    = COORD_BITS + 2;
  localparam int QB    = SB;
  localparam int MW    = 2 * D + 2;
  localparam int CNT_W = $clog2(QB);

  localparam logic [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  // sequencer
  cpsf_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // configuration
  logic signed [C-1:0] sx_q, sx_d, sy_q, sy_d, ex_q, ex_d, ey_q, ey_d;
  logic [C-1:0]        cw_q, cw_d;
  logic                act_q, act_d;
  logic [D-1:0]        len_q, len_d;
  logic                len_ok_q, len_ok_d;

  // item working registers
  logic [0:0]          opc_q, opc_d;
  logic signed [C-1:0] pz_q, pz_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                skip_q, skip_d;
  logic signed [D-1:0] rx_q, rx_d, ry_q, ry_d;
  logic [D-1:0]        dxs_q, dxs_d, dys_q, dys_d;
  logic [C-1:0]        ws_q, ws_d;
  logic [2*D-1:0]      sq_n_q, sq_n_d;
  logic [D:0]          sq_rem_q, sq_rem_d;
  logic [D-1:0]        sq_root_q, sq_root_d;
  logic [2*D-1:0]      cmag_q, cmag_d;
  logic                dneg_q, dneg_d;

  // statistics
  logic [COUNT_BITS-1:0] kept_q, kept_d;
  logic signed [SB-1:0]  smin_q, smin_d, smax_q, smax_d;
  logic signed [C-1:0]   emin_q, emin_d, emax_q, emax_d;

  // output register
  logic                  rv_q, rv_d;
  logic                  r_acc_q, r_acc_d;
  logic signed [SB-1:0]  r_sta_q, r_sta_d, r_slo_q, r_slo_d, r_shi_q, r_shi_d;
  logic signed [C-1:0]   r_elev_q, r_elev_d, r_elo_q, r_elo_d, r_ehi_q, r_ehi_d;
  logic [TAG_BITS-1:0]   r_tag_q, r_tag_d;
  logic [COUNT_BITS-1:0] r_kept_q, r_kept_d;
  logic [D-1:0]          r_len_q, r_len_d;

  // datapath wires
  logic signed [D-1:0]  dx_w, dy_w;
  logic signed [MW-1:0] cross_w, dot_w, wl_w, cneg_w, dneg_w;
  logic [2*D-1:0]       dmag_w;
  logic [QB-1:0]        quot_w, qneg_w;
  logic                 ovf_w;
  logic [2*D-1:0]       sq_ncur_w;
  logic [D+1:0]         sq_rem2_w, sq_trial_w, sq_diff_w;
  logic                 sq_ge_w;
  logic [D-1:0]         sq_root_nx_w;
  logic                 pass_w, pos_sat_w, neg_sat_w;
  logic signed [SB-1:0] sta_w;
  logic                 pt_acc_w, cfg_wr_w, out_free_w, mul_step_w;
  cpsf_mac_ctl_t        mul_ctl_w, cross_ctl_w, wl_ctl_w;
  cpsf_div_ctl_t        div_ctl_w;

  assign pt_acc_w   = pt_i.valid && pt_i.ready;
  assign cfg_wr_w   = cfg_i.valid && cfg_i.ready;
  assign out_free_w = !rv_q || res_o.ready;

  // no point item is taken in a cycle that writes a register
  assign pt_i.ready  = (state_q == ST_IDLE) && len_ok_q && !cfg_i.valid;
  assign cfg_i.ready = 1'b1;

  // line direction
  assign dx_w = D'(ex_q) - D'(sx_q);
  assign dy_w = D'(ey_q) - D'(sy_q);

  // serial multiplier control
  assign mul_step_w = (state_q == ST_LEN_MUL) || (state_q == ST_PT_MUL);
  always_comb begin
    mul_ctl_w.clr  = (state_q == ST_IDLE);
    mul_ctl_w.step = mul_step_w;
    mul_ctl_w.msb  = mul_step_w && (cnt_q == CNT_W'(D - 1));
    mul_ctl_w.sub1 = 1'b0;
    cross_ctl_w      = mul_ctl_w;
    cross_ctl_w.sub1 = 1'b1;
    wl_ctl_w.clr   = (state_q == ST_PT_ABS);
    wl_ctl_w.step  = (state_q == ST_PT_DIV) && (cnt_q < CNT_W'(C));
    wl_ctl_w.msb   = 1'b0;
    wl_ctl_w.sub1  = 1'b0;
    div_ctl_w.load = (state_q == ST_PT_ABS);
    div_ctl_w.step = (state_q == ST_PT_DIV);
  end

  // cross product r x d
  cpsf_smac #(.AW(D), .NSTEP(D)) u_cross (
    .clk_i  (clk_i),
    .ctl_i  (cross_ctl_w),
    .a0_i   (rx_q),
    .a1_i   (ry_q),
    .b0_i   (dys_q[0]),
    .b1_i   (dxs_q[0]),
    .prod_o (cross_w)
  );

  // dot product r . d, or d . d while the line length is derived
  cpsf_smac #(.AW(D), .NSTEP(D)) u_dot (
    .clk_i  (clk_i),
    .ctl_i  (mul_ctl_w),
    .a0_i   (rx_q),
    .a1_i   (ry_q),
    .b0_i   (dxs_q[0]),
    .b1_i   (dys_q[0]),
    .prod_o (dot_w)
  );

  // corridor width times line length
  cpsf_smac #(.AW(D + 1), .NSTEP(C)) u_wl (
    .clk_i  (clk_i),
    .ctl_i  (wl_ctl_w),
    .a0_i   ($signed({1'b0, len_q})),
    .a1_i   ('0),
    .b0_i   (ws_q[0]),
    .b1_i   (1'b0),
    .prod_o (wl_w)
  );

  // magnitudes of the products
  assign cneg_w = -cross_w;
  assign dneg_w = -dot_w;
  assign dmag_w = dot_w[MW-1] ? dneg_w[2*D-1:0] : dot_w[2*D-1:0];

  // station divider |dot| / len
  cpsf_div #(.NW(2 * D), .DW(D), .QW(QB)) u_div (
    .clk_i      (clk_i),
    .ctl_i      (div_ctl_w),
    .dividend_i (dmag_w),
    .divisor_i  (len_q),
    .quot_o     (quot_w),
    .ovf_o      (ovf_w)
  );

  // square root step: two radicand bits in, one root bit out
  always_comb begin
    sq_ncur_w    = (cnt_q == '0) ? dot_w[2*D-1:0] : sq_n_q;
    sq_rem2_w    = {sq_rem_q[D-1:0], sq_ncur_w[2*D-1 -: 2]};
    sq_trial_w   = {sq_root_q, 2'b01};
    sq_ge_w      = sq_rem2_w >= sq_trial_w;
    sq_diff_w    = sq_rem2_w - sq_trial_w;
    sq_root_nx_w = {sq_root_q[D-2:0], sq_ge_w};
  end

  // corridor test and saturated station
  always_comb begin
    pass_w    = !skip_q && ({1'b0, cmag_q, 1'b0} <= $unsigned(wl_w));
    qneg_w    = '0 - quot_w;
    pos_sat_w = ovf_w || quot_w[QB-1];
    neg_sat_w = ovf_w || (quot_w[QB-1] && (|quot_w[QB-2:0]));
    if (dneg_q) begin
      sta_w = neg_sat_w ? $signed(SMIN) : $signed(qneg_w);
    end else begin
      sta_w = pos_sat_w ? $signed(SMAX) : $signed(quot_w);
    end
  end

  // next state and register updates
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    ex_d      = ex_q;
    ey_d      = ey_q;
    cw_d      = cw_q;
    act_d     = act_q;
    len_d     = len_q;
    len_ok_d  = len_ok_q;
    opc_d     = opc_q;
    pz_d      = pz_q;
    tag_d     = tag_q;
    skip_d    = skip_q;
    rx_d      = rx_q;
    ry_d      = ry_q;
    dxs_d     = dxs_q;
    dys_d     = dys_q;
    ws_d      = ws_q;
    sq_n_d    = sq_n_q;
    sq_rem_d  = sq_rem_q;
    sq_root_d = sq_root_q;
    cmag_d    = cmag_q;
    dneg_d    = dneg_q;
    kept_d    = kept_q;
    smin_d    = smin_q;
    smax_d    = smax_q;
    emin_d    = emin_q;
    emax_d    = emax_q;
    rv_d      = rv_q && !res_o.ready;
    r_acc_d   = r_acc_q;
    r_sta_d   = r_sta_q;
    r_elev_d  = r_elev_q;
    r_tag_d   = r_tag_q;
    r_kept_d  = r_kept_q;
    r_slo_d   = r_slo_q;
    r_shi_d   = r_shi_q;
    r_elo_d   = r_elo_q;
    r_ehi_d   = r_ehi_q;
    r_len_d   = r_len_q;

    // register writes; any write invalidates the cached line length
    if (cfg_wr_w) begin
      len_ok_d = 1'b0;
      unique case (cfg_i.index)
        REG_START_X: sx_d = $signed(cfg_i.data);
        REG_START_Y: sy_d = $signed(cfg_i.data);
        REG_END_X:   ex_d = $signed(cfg_i.data);
        REG_END_Y:   ey_d = $signed(cfg_i.data);
        REG_WIDTH:   cw_d = cfg_i.data;
        REG_ACTIVE:  act_d = cfg_i.data[0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        cnt_d     = '0;
        sq_rem_d  = '0;
        sq_root_d = '0;
        if (cfg_wr_w) begin
          state_d = ST_IDLE;
        end else if (!len_ok_q) begin
          rx_d    = dx_w;
          ry_d    = dy_w;
          dxs_d   = dx_w;
          dys_d   = dy_w;
          state_d = ST_LEN_MUL;
        end else if (pt_acc_w) begin
          opc_d  = pt_i.opcode;
          pz_d   = pt_i.point_z;
          tag_d  = pt_i.node_tag;
          rx_d   = D'(pt_i.point_x) - D'(sx_q);
          ry_d   = D'(pt_i.point_y) - D'(sy_q);
          dxs_d  = dx_w;
          dys_d  = dy_w;
          skip_d = (pt_i.opcode == OP_CLEAR) || !act_q || (len_q == '0);
          state_d = ((pt_i.opcode == OP_CLEAR) || !act_q || (len_q == '0)) ?
                    ST_FINISH : ST_PT_MUL;
        end
      end

      ST_LEN_MUL: begin
        dxs_d = dxs_q >> 1;
        dys_d = dys_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(D - 1)) begin
          cnt_d   = '0;
          state_d = ST_LEN_SQRT;
        end
        if (cfg_wr_w) begin
          state_d = ST_IDLE;
        end
      end

      ST_LEN_SQRT: begin
        sq_n_d    = {sq_ncur_w[2*D-3:0], 2'b00};
        sq_rem_d  = sq_ge_w ? sq_diff_w[D:0] : sq_rem2_w[D:0];
        sq_root_d = sq_root_nx_w;
        cnt_d     = cnt_q + 1'b1;
        if (cfg_wr_w) begin
          state_d = ST_IDLE;
        end else if (cnt_q == CNT_W'(D - 1)) begin
          len_d    = sq_root_nx_w;
          len_ok_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_PT_MUL: begin
        dxs_d = dxs_q >> 1;
        dys_d = dys_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(D - 1)) begin
          state_d = ST_PT_ABS;
        end
      end

      ST_PT_ABS: begin
        cmag_d  = cross_w[MW-1] ? cneg_w[2*D-1:0] : cross_w[2*D-1:0];
        dneg_d  = dot_w[MW-1];
        ws_d    = cw_q;
        cnt_d   = '0;
        state_d = ST_PT_DIV;
      end

      ST_PT_DIV: begin
        ws_d  = ws_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QB - 1)) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free_w) begin
          rv_d     = 1'b1;
          r_acc_d  = 1'b0;
          r_sta_d  = '0;
          r_elev_d = '0;
          r_tag_d  = '0;
          if (opc_q == OP_CLEAR) begin
            kept_d = '0;
            smin_d = '0;
            smax_d = '0;
            emin_d = '0;
            emax_d = '0;
          end else begin
            r_tag_d = tag_q;
            if (pass_w) begin
              r_acc_d  = 1'b1;
              r_sta_d  = sta_w;
              r_elev_d = pz_q;
              if (kept_q == '0) begin
                smin_d = sta_w;
                smax_d = sta_w;
                emin_d = pz_q;
                emax_d = pz_q;
              end else begin
                if (sta_w < smin_q) smin_d = sta_w;
                if (sta_w > smax_q) smax_d = sta_w;
                if (pz_q < emin_q) emin_d = pz_q;
                if (pz_q > emax_q) emax_d = pz_q;
              end
              if (kept_q != {COUNT_BITS{1'b1}}) begin
                kept_d = kept_q + 1'b1;
              end
            end
          end
          // statistics and line length read as zero while nothing is kept
          r_kept_d = kept_d;
          if (kept_d != '0) begin
            r_slo_d = smin_d;
            r_shi_d = smax_d;
            r_elo_d = emin_d;
            r_ehi_d = emax_d;
            r_len_d = len_q;
          end else begin
            r_slo_d = '0;
            r_shi_d = '0;
            r_elo_d = '0;
            r_ehi_d = '0;
            r_len_d = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      ex_q     <= '0;
      ey_q     <= '0;
      cw_q     <= C'(WIDTH_RESET);
      act_q    <= 1'b0;
      len_ok_q <= 1'b0;
      kept_q   <= '0;
      smin_q   <= '0;
      smax_q   <= '0;
      emin_q   <= '0;
      emax_q   <= '0;
      rv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      ex_q     <= ex_d;
      ey_q     <= ey_d;
      cw_q     <= cw_d;
      act_q    <= act_d;
      len_ok_q <= len_ok_d;
      kept_q   <= kept_d;
      smin_q   <= smin_d;
      smax_q   <= smax_d;
      emin_q   <= emin_d;
      emax_q   <= emax_d;
      rv_q     <= rv_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    opc_q     <= opc_d;
    pz_q      <= pz_d;
    tag_q     <= tag_d;
    skip_q    <= skip_d;
    rx_q      <= rx_d;
    ry_q      <= ry_d;
    dxs_q     <= dxs_d;
    dys_q     <= dys_d;
    ws_q      <= ws_d;
    sq_n_q    <= sq_n_d;
    sq_rem_q  <= sq_rem_d;
    sq_root_q <= sq_root_d;
    cmag_q    <= cmag_d;
    dneg_q    <= dneg_d;
    r_acc_q   <= r_acc_d;
    r_sta_q   <= r_sta_d;
    r_elev_q  <= r_elev_d;
    r_tag_q   <= r_tag_d;
    r_kept_q  <= r_kept_d;
    r_slo_q   <= r_slo_d;
    r_shi_q   <= r_shi_d;
    r_elo_q   <= r_elo_d;
    r_ehi_q   <= r_ehi_d;
    r_len_q   <= r_len_d;
  end

  // result channel
  assign res_o.valid          = rv_q;
  assign res_o.accepted       = r_acc_q;
  assign res_o.station        = r_sta_q;
  assign res_o.elevation      = r_elev_q;
  assign res_o.tag_out        = r_tag_q;
  assign res_o.kept_count     = r_kept_q;
  assign res_o.station_low    = r_slo_q;
  assign res_o.station_high   = r_shi_q;
  assign res_o.elevation_low  = r_elo_q;
  assign res_o.elevation_high = r_ehi_q;
  assign res_o.line_length    = r_len_q;

endmodule
